// ----- src/sorted_weighted_pick_table_top_assert.svh -----
// assertion macros shared by the checker
`ifndef SORTED_WEIGHTED_PICK_TABLE_TOP_ASSERT_SVH
`define SORTED_WEIGHTED_PICK_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ----- src/swpt_pkg.sv -----
`default_nettype none
package swpt_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned MASS_W     = 32;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned TOTAL_W    = 22;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_MASS = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_REMOVE   = 3'd1,
    KIND_UNIFORM  = 3'd2,
    KIND_WEIGHTED = 3'd3,
    KIND_READ     = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2,
    STATUS_NONE      = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MASS_W-1:0] mass;
    logic [RATE_W-1:0] rate;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/sorted_weighted_pick_table_top.sv -----
// one item at a time; the next input transfer waits until the result is registered
// insert: moves heavier entries up a slot from the top down, then writes the new entry
// remove: shifts later entries down a slot; weighted pick walks the slots from slot 1 up
// a stalled output holds off the next input transfer
// the scan walks one table slot per cycle through the single-read-port entry memory
// reset: count 1, rate total 0, resource id and mass 0; entry memory left undefined
`default_nettype none
module sorted_weighted_pick_table_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [swpt_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [swpt_pkg::ID_W-1:0]         species_id_i,
  input  wire logic [swpt_pkg::MASS_W-1:0]       body_mass_i,
  input  wire logic [swpt_pkg::RATE_W-1:0]       dispersal_rate_i,
  input  wire logic [swpt_pkg::IDX_W-1:0]        entry_index_i,
  input  wire logic [swpt_pkg::FRAC_W-1:0]       random_fraction_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [swpt_pkg::STATUS_W-1:0]     status_o,
  output logic      [swpt_pkg::ID_W-1:0]         result_id_o,
  output logic      [swpt_pkg::POS_W-1:0]        position_o,
  output logic      [swpt_pkg::CNT_W-1:0]        entry_count_o,
  output logic                                   table_full_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [swpt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [swpt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import swpt_pkg::*;

  localparam int unsigned IW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW   = RATE_W + IW;
  localparam int unsigned CMPW = (SW > TOTAL_W) ? SW : TOTAL_W;
  localparam int unsigned XW   = (CW > CNT_W) ? CW : CNT_W;
  localparam int unsigned UW   = CW + FRAC_W;
  localparam int unsigned WW   = TOTAL_W + FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_RM_GET,
    ST_RM_SHIFT,
    ST_UNI_RD,
    ST_GET,
    ST_WP_WALK,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [TOTAL_W-1:0] rate_total_q, rate_total_d;
  logic [ID_W-1:0]    resource_id_q, resource_id_d;
  logic [MASS_W-1:0]  resource_mass_q, resource_mass_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [CNT_W-1:0]   out_count_q, out_count_d;
  logic               out_full_q, out_full_d;

  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [ID_W-1:0]    species_id_q, species_id_d;
  logic [MASS_W-1:0]  body_mass_q, body_mass_d;
  logic [RATE_W-1:0]  dispersal_rate_q, dispersal_rate_d;
  logic [IDX_W-1:0]   entry_index_q, entry_index_d;
  logic [FRAC_W-1:0]  random_fraction_q, random_fraction_d;
  logic [IW-1:0]      ptr_q, ptr_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [TOTAL_W-1:0] target_q, target_d;
  status_e            res_status_q, res_status_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;
  logic [IW-1:0]      res_pos_q, res_pos_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;

  logic          accept, idx_ok, more, heavier, hit;
  logic [XW-1:0] count_ext, idx_ext, pos_ext;
  logic [IW-1:0] idx_addr;
  logic [UW-1:0] uni_prod;
  logic [WW-1:0] wp_prod;
  logic [SW-1:0] sum_new;
  entry_t        new_entry;

  swpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;

  assign count_ext = XW'(count_q);
  assign idx_ext   = XW'(entry_index_q);
  assign idx_ok    = (idx_ext < count_ext);
  assign idx_addr  = idx_ext[IW-1:0];
  assign more      = ((CW'(ptr_q) + CW'(1)) < count_q);
  assign heavier   = (body_mass_q < rd.mass);
  assign uni_prod  = UW'(count_q - CW'(1)) * UW'(random_fraction_q);
  assign wp_prod   = WW'(rate_total_q) * WW'(random_fraction_q);
  assign sum_new   = sum_q + SW'(rd.rate);
  assign hit       = (CMPW'(target_q) < CMPW'(sum_new));
  assign pos_ext   = XW'(res_pos_q);
  assign new_entry = '{id: species_id_q, mass: body_mass_q, rate: dispersal_rate_q};

  always_comb begin
    state_d           = state_q;
    count_d           = count_q;
    rate_total_d      = rate_total_q;
    resource_id_d     = resource_id_q;
    resource_mass_d   = resource_mass_q;
    out_valid_d       = out_valid_q && out_stall_i;
    out_status_d      = out_status_q;
    out_id_d          = out_id_q;
    out_pos_d         = out_pos_q;
    out_count_d       = out_count_q;
    out_full_d        = out_full_q;
    kind_d            = kind_q;
    species_id_d      = species_id_q;
    body_mass_d       = body_mass_q;
    dispersal_rate_d  = dispersal_rate_q;
    entry_index_d     = entry_index_q;
    random_fraction_d = random_fraction_q;
    ptr_d             = ptr_q;
    sum_d             = sum_q;
    target_d          = target_q;
    res_status_d      = res_status_q;
    res_id_d          = res_id_q;
    res_pos_d         = res_pos_q;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = '0;

    case (state_q)
      ST_IDLE: begin
        // resource entry is mirrored into slot 0
        if (cfg_valid_i) begin
          case (cfg_index_i)
            CFG_RESOURCE_ID:   resource_id_d   = cfg_data_i[ID_W-1:0];
            CFG_RESOURCE_MASS: resource_mass_d = cfg_data_i[MASS_W-1:0];
            default:           resource_id_d   = resource_id_q;
          endcase
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = '{id: resource_id_d, mass: resource_mass_d, rate: '0};
        end
        if (accept) begin
          kind_d            = kind_i;
          species_id_d      = species_id_i;
          body_mass_d       = body_mass_i;
          dispersal_rate_d  = dispersal_rate_i;
          entry_index_d     = entry_index_i;
          random_fraction_d = random_fraction_i;
          state_d           = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_status_d = STATUS_OK;
        res_id_d     = '0;
        res_pos_d    = '0;
        state_d      = ST_DONE;
        case (kind_q)
          KIND_INSERT: begin
            if (count_q >= CW'(TABLE_DEPTH)) begin
              res_status_d = STATUS_FULL;
            end else if (count_q == CW'(1)) begin
              ptr_d   = IW'(1);
              state_d = ST_INS_PUT;
            end else begin
              ptr_d     = IW'(count_q - CW'(1));
              ram_re    = 1'b1;
              ram_raddr = IW'(count_q - CW'(1));
              state_d   = ST_INS_SCAN;
            end
          end
          KIND_REMOVE: begin
            if (!idx_ok || idx_ext == '0) begin
              res_status_d = STATUS_BAD_INDEX;
            end else begin
              ptr_d     = idx_addr;
              ram_re    = 1'b1;
              ram_raddr = idx_addr;
              state_d   = ST_RM_GET;
            end
          end
          KIND_UNIFORM: begin
            if (count_q <= CW'(1)) begin
              res_status_d = STATUS_NONE;
            end else begin
              ptr_d   = IW'(uni_prod[UW-1:FRAC_W]) + IW'(1);
              state_d = ST_UNI_RD;
            end
          end
          KIND_WEIGHTED: begin
            target_d = wp_prod[WW-1:FRAC_W];
            if (count_q <= CW'(1)) begin
              res_status_d = STATUS_NONE;
            end else begin
              sum_d     = '0;
              ptr_d     = IW'(1);
              ram_re    = 1'b1;
              ram_raddr = IW'(1);
              state_d   = ST_WP_WALK;
            end
          end
          KIND_READ: begin
            if (!idx_ok) begin
              res_status_d = STATUS_BAD_INDEX;
            end else if (idx_ext == '0) begin
              res_id_d = resource_id_q;
            end else begin
              ptr_d     = idx_addr;
              ram_re    = 1'b1;
              ram_raddr = idx_addr;
              state_d   = ST_GET;
            end
          end
          default: begin
            res_status_d = STATUS_OK;
          end
        endcase
      end

      ST_INS_SCAN: begin
        // read data is slot ptr_q
        if (heavier) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q + IW'(1);
          ram_wdata = rd;
          if (ptr_q == IW'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q - IW'(1);
            ptr_d     = ptr_q - IW'(1);
          end
        end else begin
          ptr_d   = ptr_q + IW'(1);
          state_d = ST_INS_PUT;
        end
      end

      ST_INS_PUT: begin
        ram_we       = 1'b1;
        ram_waddr    = ptr_q;
        ram_wdata    = new_entry;
        count_d      = count_q + CW'(1);
        rate_total_d = rate_total_q + TOTAL_W'(dispersal_rate_q);
        res_status_d = STATUS_OK;
        res_id_d     = species_id_q;
        res_pos_d    = ptr_q;
        state_d      = ST_DONE;
      end

      ST_RM_GET: begin
        res_id_d     = rd.id;
        res_pos_d    = ptr_q;
        rate_total_d = rate_total_q - TOTAL_W'(rd.rate);
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + IW'(1);
          ptr_d     = ptr_q + IW'(1);
          state_d   = ST_RM_SHIFT;
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_RM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - IW'(1);
        ram_wdata = rd;
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + IW'(1);
          ptr_d     = ptr_q + IW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_UNI_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
        state_d   = ST_GET;
      end

      ST_GET: begin
        res_id_d  = rd.id;
        res_pos_d = ptr_q;
        state_d   = ST_DONE;
      end

      ST_WP_WALK: begin
        if (hit) begin
          res_id_d  = rd.id;
          res_pos_d = ptr_q;
          state_d   = ST_DONE;
        end else begin
          sum_d = sum_new;
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q + IW'(1);
            ptr_d     = ptr_q + IW'(1);
          end else begin
            res_status_d = STATUS_NONE;
            state_d      = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_pos_d    = pos_ext[POS_W-1:0];
          out_count_d  = count_ext[CNT_W-1:0];
          out_full_d   = (count_q >= CW'(TABLE_DEPTH));
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      count_q         <= CW'(1);
      rate_total_q    <= '0;
      resource_id_q   <= '0;
      resource_mass_q <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= STATUS_OK;
      out_id_q        <= '0;
      out_pos_q       <= '0;
      out_count_q     <= '0;
      out_full_q      <= 1'b0;
    end else begin
      state_q         <= state_d;
      count_q         <= count_d;
      rate_total_q    <= rate_total_d;
      resource_id_q   <= resource_id_d;
      resource_mass_q <= resource_mass_d;
      out_valid_q     <= out_valid_d;
      out_status_q    <= out_status_d;
      out_id_q        <= out_id_d;
      out_pos_q       <= out_pos_d;
      out_count_q     <= out_count_d;
      out_full_q      <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q            <= kind_d;
    species_id_q      <= species_id_d;
    body_mass_q       <= body_mass_d;
    dispersal_rate_q  <= dispersal_rate_d;
    entry_index_q     <= entry_index_d;
    random_fraction_q <= random_fraction_d;
    ptr_q             <= ptr_d;
    sum_q             <= sum_d;
    target_q          <= target_d;
    res_status_q      <= res_status_d;
    res_id_q          <= res_id_d;
    res_pos_q         <= res_pos_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_id_o   = out_id_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_count_q;
  assign table_full_o  = out_full_q;

endmodule
`default_nettype wire

// ----- src/swpt_ram.sv -----
`default_nettype none
module swpt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- src/swpt_checker.sv -----
`default_nettype none
`include "sorted_weighted_pick_table_top_assert.svh"
module swpt_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [swpt_pkg::STATUS_W-1:0] status_o,
  input wire logic [swpt_pkg::ID_W-1:0]     result_id_o,
  input wire logic [swpt_pkg::POS_W-1:0]    position_o,
  input wire logic                          table_full_o
);

  import swpt_pkg::*;

  `ASSERT_NEXT(out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(out_payload_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(status_o) && $stable(result_id_o) && $stable(position_o))
  `ASSERT_IMPLY(full_status_flag, clk_i, rst_ni, out_valid_o && status_o == STATUS_FULL, table_full_o)
  `ASSERT_IMPLY(error_fields_zero, clk_i, rst_ni, out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_BAD_INDEX || status_o == STATUS_NONE), result_id_o == '0 && position_o == '0)

endmodule

bind sorted_weighted_pick_table_top swpt_checker u_swpt_checker (.*);
`default_nettype wire
